// ===== src/rtph_pkg.sv =====
// Shared constants, codes and types for the RTP header parser.
package rtph_pkg;

  // Packet length bound; a byte at or beyond this position marks the packet oversize.
  localparam int MAX_PACKET_BYTES = 2048;

  // Result queue depth and pointer width.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Fixed header layout.
  localparam logic [7:0] FIXED_HDR_BYTES = 8'd12;
  localparam logic [1:0] HDR_VERSION = 2'd2;
  localparam logic [15:0] ONE_BYTE_PROFILE = 16'hBEDE;
  localparam logic [17:0] BLOCK_END_MAX = 18'h3FFFF;

  // Summary status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_ZERO_PAD    = 3'd3;
  localparam logic [2:0] ST_EXT_HEADER  = 3'd4;
  localparam logic [2:0] ST_EXT_OVERRUN = 3'd5;
  localparam logic [2:0] ST_PAD_OVERRUN = 3'd6;

  // Extension element walk phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WALK    = 2'd1;
  localparam logic [1:0] PH_LEN     = 2'd2;

  typedef struct packed {
    logic        is_summary;
    logic [2:0]  status;
    logic        marker;
    logic [6:0]  media_type;
    logic [15:0] sequence_number;
    logic [31:0] timestamp_value;
    logic [31:0] ssrc_value;
    logic [3:0]  csrc_count;
    logic [15:0] byte_offset;
    logic [15:0] byte_length;
    logic [7:0]  padding_count;
    logic [7:0]  element_id;
  } rtph_result_t;

  // Results produced by one accepted item: an optional record, then an optional summary.
  typedef struct packed {
    logic         rec_valid;
    logic         sum_valid;
    rtph_result_t rec;
    rtph_result_t sum;
  } rtph_push_t;

endpackage

// ===== src/rtph_parse.sv =====
// Per-byte parsing state and the combinational logic that forms records and summaries.
module rtph_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               final_byte,
  output rtph_pkg::rtph_push_t push
);
  import rtph_pkg::*;

  logic [15:0] byte_position;
  logic [7:0]  first_header_byte;
  logic [7:0]  second_header_byte;
  logic [15:0] seq_reg;
  logic [31:0] timestamp_reg;
  logic [31:0] ssrc_reg;
  logic [15:0] ext_profile;
  logic [17:0] ext_block_end;
  logic [1:0]  element_phase;
  logic [8:0]  element_skip_left;
  logic [7:0]  element_id_reg;
  logic        oversize;

  logic [15:0] byte_position_next;
  logic [7:0]  first_header_byte_next;
  logic [7:0]  second_header_byte_next;
  logic [15:0] seq_reg_next;
  logic [31:0] timestamp_reg_next;
  logic [31:0] ssrc_reg_next;
  logic [15:0] ext_profile_next;
  logic [17:0] ext_block_end_next;
  logic [1:0]  element_phase_next;
  logic [8:0]  element_skip_left_next;
  logic [7:0]  element_id_reg_next;

  localparam logic [16:0] MAX_POS = 17'(MAX_PACKET_BYTES);

  logic        oversize_now;
  logic [15:0] ext_base;
  logic [18:0] block_end_full;
  logic        ext_active;
  logic        rec_valid;
  logic [15:0] rec_length;
  logic [7:0]  rec_id;

  assign oversize_now = oversize || ({1'b0, byte_position} >= MAX_POS);
  assign ext_base = 16'(FIXED_HDR_BYTES) + {10'd0, first_header_byte[3:0], 2'b00};
  assign block_end_full = 19'(ext_base) + 19'd4
                          + {1'b0, ext_block_end[7:0], data_byte, 2'b00};
  assign ext_active = first_header_byte[4] && (first_header_byte[7:6] == HDR_VERSION)
                      && (byte_position >= 16'(FIXED_HDR_BYTES));

  always_comb begin
    first_header_byte_next  = first_header_byte;
    second_header_byte_next = second_header_byte;
    seq_reg_next            = seq_reg;
    timestamp_reg_next      = timestamp_reg;
    ssrc_reg_next           = ssrc_reg;
    ext_profile_next        = ext_profile;
    ext_block_end_next      = ext_block_end;
    element_phase_next      = element_phase;
    element_skip_left_next  = element_skip_left;
    element_id_reg_next     = element_id_reg;
    rec_valid               = 1'b0;
    rec_length              = '0;
    rec_id                  = '0;
    if (!oversize_now) begin
      if (byte_position == 16'd0) begin
        first_header_byte_next = data_byte;
      end else if (byte_position == 16'd1) begin
        second_header_byte_next = data_byte;
      end else if (byte_position < 16'd4) begin
        seq_reg_next = {seq_reg[7:0], data_byte};
      end else if (byte_position < 16'd8) begin
        timestamp_reg_next = {timestamp_reg[23:0], data_byte};
      end else if (byte_position < 16'd12) begin
        ssrc_reg_next = {ssrc_reg[23:0], data_byte};
      end else if (ext_active) begin
        if (byte_position == ext_base) begin
          ext_profile_next = {data_byte, 8'd0};
        end else if (byte_position == ext_base + 16'd1) begin
          ext_profile_next = {ext_profile[15:8], data_byte};
        end else if (byte_position == ext_base + 16'd2) begin
          ext_block_end_next = {10'd0, data_byte};
        end else if (byte_position == ext_base + 16'd3) begin
          ext_block_end_next = (block_end_full > 19'(BLOCK_END_MAX)) ? BLOCK_END_MAX
                                                                     : block_end_full[17:0];
          element_phase_next     = PH_WALK;
          element_skip_left_next = '0;
        end else if (byte_position > ext_base + 16'd3) begin
          if (element_phase == PH_WALK) begin
            if (element_skip_left != 9'd0) begin
              element_skip_left_next = element_skip_left - 9'd1;
            end else if ({2'b00, byte_position} < ext_block_end) begin
              if (data_byte != 8'd0) begin
                if (ext_profile == ONE_BYTE_PROFILE) begin
                  rec_valid              = 1'b1;
                  rec_length             = {12'd0, data_byte[3:0]} + 16'd1;
                  rec_id                 = {4'd0, data_byte[7:4]};
                  element_skip_left_next = {5'd0, data_byte[3:0]} + 9'd1;
                end else begin
                  element_id_reg_next = data_byte;
                  element_phase_next  = PH_LEN;
                end
              end
            end else begin
              element_phase_next = PH_IDLE;
            end
          end else if (element_phase == PH_LEN) begin
            rec_valid              = 1'b1;
            rec_length             = {8'd0, data_byte};
            rec_id                 = element_id_reg;
            element_skip_left_next = {1'b0, data_byte};
            element_phase_next     = PH_WALK;
          end
        end
      end
    end
  end

  assign byte_position_next = (byte_position != 16'hFFFF) ? byte_position + 16'd1
                                                           : byte_position;

  // Summary, formed from the state as it stands after this byte.
  logic [18:0] total;
  logic [7:0]  pad;
  logic [18:0] hdr_end;
  logic [18:0] pay_off;
  logic [2:0]  sum_status;
  logic [18:0] pay_len;

  assign total   = {3'd0, byte_position} + 19'd1;
  assign pad     = first_header_byte_next[5] ? data_byte : 8'd0;
  assign hdr_end = 19'(FIXED_HDR_BYTES) + {13'd0, first_header_byte_next[3:0], 2'b00};

  always_comb begin
    sum_status = ST_OK;
    pay_off    = hdr_end;
    if (oversize_now) begin
      sum_status = ST_PAD_OVERRUN;
    end else if (total < 19'(FIXED_HDR_BYTES)) begin
      sum_status = ST_SHORT;
    end else if (first_header_byte_next[7:6] != HDR_VERSION) begin
      sum_status = ST_BAD_VERSION;
    end else if (first_header_byte_next[5] && (pad == 8'd0)) begin
      sum_status = ST_ZERO_PAD;
    end else begin
      if (first_header_byte_next[4]) begin
        if (hdr_end + 19'd4 > total) begin
          sum_status = ST_EXT_HEADER;
        end else if ({1'b0, ext_block_end_next} > total) begin
          sum_status = ST_EXT_OVERRUN;
        end else begin
          pay_off = {1'b0, ext_block_end_next};
        end
      end
      if ((sum_status == ST_OK) && (pay_off + {11'd0, pad} > total)) begin
        sum_status = ST_PAD_OVERRUN;
      end
    end
  end

  assign pay_len = total - pay_off - {11'd0, pad};

  always_comb begin
    push.rec_valid = accept && rec_valid;
    push.sum_valid = accept && final_byte;

    push.rec.is_summary      = 1'b0;
    push.rec.status          = ST_OK;
    push.rec.marker          = second_header_byte_next[7];
    push.rec.media_type      = second_header_byte_next[6:0];
    push.rec.sequence_number = seq_reg_next;
    push.rec.timestamp_value = timestamp_reg_next;
    push.rec.ssrc_value      = ssrc_reg_next;
    push.rec.csrc_count      = first_header_byte_next[3:0];
    push.rec.byte_offset     = byte_position + 16'd1;
    push.rec.byte_length     = rec_length;
    push.rec.padding_count   = 8'd0;
    push.rec.element_id      = rec_id;

    push.sum                 = push.rec;
    push.sum.is_summary      = 1'b1;
    push.sum.status          = sum_status;
    push.sum.byte_offset     = (sum_status == ST_OK) ? pay_off[15:0] : 16'd0;
    push.sum.byte_length     = (sum_status == ST_OK) ? pay_len[15:0] : 16'd0;
    push.sum.padding_count   = pad;
    push.sum.element_id      = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      byte_position      <= '0;
      first_header_byte  <= '0;
      second_header_byte <= '0;
      seq_reg            <= '0;
      timestamp_reg      <= '0;
      ssrc_reg           <= '0;
      ext_profile        <= '0;
      ext_block_end      <= '0;
      element_phase      <= PH_IDLE;
      element_skip_left  <= '0;
      element_id_reg     <= '0;
      oversize           <= 1'b0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      first_header_byte  <= first_header_byte_next;
      second_header_byte <= second_header_byte_next;
      seq_reg            <= seq_reg_next;
      timestamp_reg      <= timestamp_reg_next;
      ssrc_reg           <= ssrc_reg_next;
      ext_profile        <= ext_profile_next;
      ext_block_end      <= ext_block_end_next;
      element_phase      <= element_phase_next;
      element_skip_left  <= element_skip_left_next;
      element_id_reg     <= element_id_reg_next;
      oversize           <= oversize_now;
    end
  end

endmodule

// ===== src/rtph_out_queue.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
module rtph_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  rtph_pkg::rtph_push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtph_pkg::rtph_result_t head
);
  import rtph_pkg::*;

  rtph_result_t     entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  logic              pop;
  logic [1:0]        n_push;
  rtph_result_t      first_entry;

  assign out_valid   = (count != '0);
  assign pop         = out_valid && out_ready;
  assign n_push      = {1'b0, push.rec_valid} + {1'b0, push.sum_valid};
  assign first_entry = push.rec_valid ? push.rec : push.sum;
  // Two free slots must remain so that a record and a summary both fit.
  assign room        = (count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= first_entry;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ===== src/rtp_header_parser.sv =====
// Top level of the RTP header parser: byte input channel and result output channel.
//
// The parser takes one RTP packet byte per item on the input channel, with
// final_byte marking the last byte, and reports on the output channel. Each byte
// is processed in the cycle it is accepted, so one byte per clock is sustained
// while the output side keeps taking results; the figure is set by the per-byte
// parse logic, which updates the header and extension-walk registers in a single
// pass. A result is written into the output queue when its byte is accepted.
// Every header extension element (one-byte headers under profile 0xBEDE,
// two-byte headers otherwise) yields one record item carrying its id, data offset
// and length. The final byte yields one summary item with the status, the payload
// offset and size, and the padding count; when an element record and the summary
// fall on the same byte, the record comes first. A consumer should drop the
// records of a packet whose summary has a nonzero status. Results pass through a
// four-entry queue; input is taken whenever at least two entries are free, so a
// stalled output side holds back the input once three results are waiting. Header
// fields in every result reflect the bytes captured so far, and bytes not yet
// received read as zero. Packets longer than the length bound report status 6,
// and all state returns to its reset value after each final byte.
module rtp_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_summary,
  output logic [2:0]  status,
  output logic        marker,
  output logic [6:0]  media_type,
  output logic [15:0] sequence_number,
  output logic [31:0] timestamp_value,
  output logic [31:0] ssrc_value,
  output logic [3:0]  csrc_count,
  output logic [15:0] byte_offset,
  output logic [15:0] byte_length,
  output logic [7:0]  padding_count,
  output logic [7:0]  element_id
);
  import rtph_pkg::*;

  logic         accept;
  rtph_push_t   push;
  rtph_result_t head;

  // A byte is consumed on any edge where both sides of the input handshake agree.
  assign accept = in_valid && in_ready;

  rtph_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .push       (push)
  );

  rtph_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // The queue head drives the output fields directly.
  assign is_summary      = head.is_summary;
  assign status          = head.status;
  assign marker          = head.marker;
  assign media_type      = head.media_type;
  assign sequence_number = head.sequence_number;
  assign timestamp_value = head.timestamp_value;
  assign ssrc_value      = head.ssrc_value;
  assign csrc_count      = head.csrc_count;
  assign byte_offset     = head.byte_offset;
  assign byte_length     = head.byte_length;
  assign padding_count   = head.padding_count;
  assign element_id      = head.element_id;

endmodule

// ===== src/rtph_checker.sv =====
// Port-level checks for the RTP header parser and the bind that attaches them.
module rtph_assertions (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_summary,
  input logic [2:0]  status,
  input logic [15:0] byte_offset,
  input logic [15:0] byte_length,
  input logic [7:0]  padding_count,
  input logic [7:0]  element_id
);
  import rtph_pkg::*;

  // Output valid stays high while a waiting result is not taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Element records never carry a status or padding.
  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_summary |-> (status == ST_OK) && (padding_count == 8'd0))
    else $error("record item with status or padding");

  // Error summaries carry no offset, length or element id.
  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_summary && (status != ST_OK) |->
      (byte_offset == 16'd0) && (byte_length == 16'd0) && (element_id == 8'd0))
    else $error("error summary with offset, length or id");

endmodule

bind rtp_header_parser rtph_assertions u_rtph_assertions (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_summary    (is_summary),
  .status        (status),
  .byte_offset   (byte_offset),
  .byte_length   (byte_length),
  .padding_count (padding_count),
  .element_id    (element_id)
);
